/* src/lmd_pkg.sv */
// Package for the 3x3 local maximum detector.
// Holds the word types of both channels, the register codes and the shared constants.
// No dependencies.
package lmd_pkg;

	localparam int PIXEL_BITS = 16;
	localparam int MAX_WIDTH_DEFAULT = 1024;
	localparam int WIDTH_REG_BITS = 11;
	localparam int HEIGHT_REG_BITS = 13;
	localparam int CFG_DATA_BITS = 13;
	localparam int ROW_CNT_BITS = 13;
	localparam int ROW_OUT_BITS = 12;
	localparam int COL_OUT_BITS = 10;

	localparam logic [WIDTH_REG_BITS-1:0] WIDTH_RESET = 11'd1024;
	localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 13'd1024;
	localparam logic [ROW_CNT_BITS-1:0] HEIGHT_LIMIT = 13'd4096;

	typedef enum logic [0:0] {
		REG_FRAME_WIDTH = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic signed [PIXEL_BITS-1:0] pixel_value;
		logic drain;
	} in_word_t;

	typedef struct packed {
		logic is_maximum;
		logic signed [PIXEL_BITS-1:0] value;
		logic [ROW_OUT_BITS-1:0] row;
		logic [COL_OUT_BITS-1:0] column;
		logic frame_end;
	} out_word_t;

	// Pixel to be decided by an item, with the edges of the frame around it.
	typedef struct packed {
		logic decide;
		logic [ROW_OUT_BITS-1:0] row;
		logic [COL_OUT_BITS-1:0] column;
		logic top_ok;
		logic bottom_ok;
		logic left_ok;
		logic right_ok;
		logic frame_end;
	} dec_t;

	typedef struct packed {
		logic in_frame;
		dec_t dec;
	} pos_ctl_t;

endpackage

/* src/lmd_ctrl.sv */
// Frame geometry registers and raster position tracking for the detector.
// Decodes which pixel the next word completes. Depends on lmd_pkg.
module lmd_ctrl #(
	parameter int MAX_WIDTH = lmd_pkg::MAX_WIDTH_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input lmd_pkg::cfg_reg_t cfg_index,
	input logic [lmd_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input logic advance,
	output logic [$clog2(MAX_WIDTH)-1:0] col,
	output lmd_pkg::pos_ctl_t ctl
);
	import lmd_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);

	logic [WIDTH_REG_BITS-1:0] frame_width_q;
	logic [HEIGHT_REG_BITS-1:0] frame_height_q;
	logic [ROW_CNT_BITS-1:0] row_q;
	logic [CW-1:0] col_q;
	logic [ROW_CNT_BITS-1:0] h_eff;
	logic [ROW_CNT_BITS-1:0] dr;
	logic [WW-1:0] w_eff;
	logic [WW-1:0] dc;
	logic [WW-1:0] col_inc;
	logic in_frame;
	logic col_first;
	logic dec_a;
	logic dec_b;
	logic wrap;
	logic flush_done;

	always_comb begin
		if (frame_height_q == '0) begin
			h_eff = ROW_CNT_BITS'(1);
		end else if (frame_height_q > HEIGHT_LIMIT) begin
			h_eff = HEIGHT_LIMIT;
		end else begin
			h_eff = frame_height_q;
		end
		if (frame_width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(frame_width_q);
		end
	end

	always_comb begin
		in_frame = row_q < h_eff;
		col_first = col_q == '0;
		// The first column of a row completes the last pixel two rows up;
		// any other column completes the pixel up and to the left.
		dec_a = col_first && (row_q >= ROW_CNT_BITS'(2))
			&& ((row_q - ROW_CNT_BITS'(2)) < h_eff);
		dec_b = !col_first && (row_q != '0) && ((row_q - ROW_CNT_BITS'(1)) < h_eff);
		dr = dec_a ? row_q - ROW_CNT_BITS'(2) : row_q - ROW_CNT_BITS'(1);
		dc = dec_a ? w_eff - WW'(1) : WW'(col_q) - WW'(1);
		col_inc = WW'(col_q) + WW'(1);
		wrap = col_inc >= w_eff;
		flush_done = !in_frame && (row_q == h_eff + ROW_CNT_BITS'(1));

		ctl.in_frame = in_frame;
		ctl.dec.decide = dec_a || dec_b;
		ctl.dec.row = dr[ROW_OUT_BITS-1:0];
		ctl.dec.column = COL_OUT_BITS'(dc);
		ctl.dec.top_ok = dr != '0;
		ctl.dec.bottom_ok = dr != h_eff - ROW_CNT_BITS'(1);
		ctl.dec.left_ok = dc != '0;
		ctl.dec.right_ok = dc != w_eff - WW'(1);
		ctl.dec.frame_end = !ctl.dec.bottom_ok && !ctl.dec.right_ok;
	end

	assign col = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= WIDTH_RESET;
			frame_height_q <= HEIGHT_RESET;
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FRAME_WIDTH: frame_width_q <= cfg_data[WIDTH_REG_BITS-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[HEIGHT_REG_BITS-1:0];
				default: ;
			endcase
			row_q <= '0;
			col_q <= '0;
		end else if (advance) begin
			if (flush_done) begin
				row_q <= '0;
				col_q <= '0;
			end else if (wrap) begin
				row_q <= row_q + ROW_CNT_BITS'(1);
				col_q <= '0;
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

endmodule

/* src/lmd_line_store.sv */
// Two line stores kept as one memory word per column, holding the two rows above.
// Registered read with bypass of a write to the same column. Depends on lmd_pkg.
module lmd_line_store #(
	parameter int MAX_WIDTH = lmd_pkg::MAX_WIDTH_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic rd_en,
	input logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
	input logic wr_en,
	input logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
	input logic signed [lmd_pkg::PIXEL_BITS-1:0] wr_sample,
	output logic signed [lmd_pkg::PIXEL_BITS-1:0] upper,
	output logic signed [lmd_pkg::PIXEL_BITS-1:0] middle
);
	import lmd_pkg::*;

	logic [2*PIXEL_BITS-1:0] mem [MAX_WIDTH];
	logic [2*PIXEL_BITS-1:0] rd_q;
	logic [2*PIXEL_BITS-1:0] fwd_data_q;
	logic [2*PIXEL_BITS-1:0] eff_word;
	logic [2*PIXEL_BITS-1:0] wr_word;
	logic fwd_q;

	// The middle row moves up and the new sample becomes the middle row.
	assign wr_word = {middle, wr_sample};
	assign eff_word = fwd_q ? fwd_data_q : rd_q;
	assign upper = eff_word[2*PIXEL_BITS-1:PIXEL_BITS];
	assign middle = eff_word[PIXEL_BITS-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_word;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
			fwd_data_q <= wr_word;
		end
	end

	// A read that meets the write of the same column takes the written word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

endmodule

/* src/lmd_window.sv */
// 3x3 sample window and the neighborhood compare of its center.
// Holds the decision details of the word in the compare stage. Depends on lmd_pkg.
module lmd_window (
	input logic clk,
	input logic shift,
	input logic signed [lmd_pkg::PIXEL_BITS-1:0] upper,
	input logic signed [lmd_pkg::PIXEL_BITS-1:0] middle,
	input logic signed [lmd_pkg::PIXEL_BITS-1:0] sample,
	input lmd_pkg::dec_t dec_in,
	output lmd_pkg::dec_t dec_s2,
	output logic signed [lmd_pkg::PIXEL_BITS-1:0] center,
	output logic is_max
);
	import lmd_pkg::*;

	logic signed [PIXEL_BITS-1:0] win_q [3][3];
	logic [2:0] row_ok;
	logic [2:0] col_ok;

	always_ff @(posedge clk) begin
		if (shift) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= upper;
			win_q[1][2] <= middle;
			win_q[2][2] <= sample;
			dec_s2 <= dec_in;
		end
	end

	assign center = win_q[1][1];

	// Neighbors outside the frame take no part in the compare.
	always_comb begin
		row_ok = {dec_s2.bottom_ok, 1'b1, dec_s2.top_ok};
		col_ok = {dec_s2.right_ok, 1'b1, dec_s2.left_ok};
		is_max = 1'b1;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (!(i == 1 && j == 1) && row_ok[i] && col_ok[j]
					&& (win_q[1][1] < win_q[i][j])) begin
					is_max = 1'b0;
				end
			end
		end
	end

endmodule

/* src/local_maximum_3x3_detector.sv */
// 3x3 local maximum detector, top level. Accepts one word per cycle unless a held result
// stalls the pipeline. A pixel is decided by the word W+1 places after it; that result
// passes the line store read and the window compare into the output register. The line
// store takes one read and one write per word, which sets the rate.
// Reset clears position and valid flags and sets width and height to 1024; line store
// contents are not cleared and never reach a result. Depends on lmd_pkg and submodules.
module local_maximum_3x3_detector #(
	parameter int MAX_WIDTH = lmd_pkg::MAX_WIDTH_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input lmd_pkg::cfg_reg_t cfg_index,
	input logic [lmd_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input logic pixel_valid,
	output logic pixel_ready,
	input lmd_pkg::in_word_t pixel,
	output logic result_valid,
	input logic result_ready,
	output lmd_pkg::out_word_t result
);
	import lmd_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	pos_ctl_t ctl;
	logic [CW-1:0] col;
	logic accept;
	logic take;
	logic signed [PIXEL_BITS-1:0] sample;

	logic v_s1;
	logic signed [PIXEL_BITS-1:0] sample_s1;
	logic [CW-1:0] col_s1;
	dec_t dec_s1;
	logic v_s2;
	dec_t dec_s2;

	logic signed [PIXEL_BITS-1:0] upper;
	logic signed [PIXEL_BITS-1:0] middle;
	logic signed [PIXEL_BITS-1:0] center;
	logic is_max;

	logic s1_move;
	logic s2_move;
	logic s2_free;
	logic out_free;
	logic result_valid_q;
	out_word_t result_q;

	assign out_free = !result_valid_q || result_ready;
	assign s2_move = v_s2 && (!dec_s2.decide || out_free);
	assign s2_free = !v_s2 || s2_move;
	assign s1_move = v_s1 && s2_free;
	assign pixel_ready = !v_s1 || s1_move;
	assign accept = pixel_valid && pixel_ready;
	// A drain word while the frame still expects pixels is dropped.
	assign take = accept && !(ctl.in_frame && pixel.drain);
	assign sample = ctl.in_frame ? pixel.pixel_value : '0;

	lmd_ctrl #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.advance(take),
		.col(col),
		.ctl(ctl)
	);

	lmd_line_store #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_line_store (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(take),
		.rd_addr(col),
		.wr_en(s1_move),
		.wr_addr(col_s1),
		.wr_sample(sample_s1),
		.upper(upper),
		.middle(middle)
	);

	lmd_window u_window (
		.clk(clk),
		.shift(s1_move),
		.upper(upper),
		.middle(middle),
		.sample(sample_s1),
		.dec_in(dec_s1),
		.dec_s2(dec_s2),
		.center(center),
		.is_max(is_max)
	);

	always_ff @(posedge clk) begin
		if (take) begin
			sample_s1 <= sample;
			col_s1 <= col;
			dec_s1 <= ctl.dec;
		end
		if (s2_move && dec_s2.decide) begin
			result_q.is_maximum <= is_max;
			result_q.value <= center;
			result_q.row <= dec_s2.row;
			result_q.column <= dec_s2.column;
			result_q.frame_end <= dec_s2.frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (take) begin
				v_s1 <= 1'b1;
			end else if (s1_move) begin
				v_s1 <= 1'b0;
			end
			if (s1_move) begin
				v_s2 <= 1'b1;
			end else if (s2_move) begin
				v_s2 <= 1'b0;
			end
			if (s2_move && dec_s2.decide) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !result_ready |-> !(s2_move && dec_s2.decide))
		else $error("pending result overwritten by compare stage");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(s2_move && dec_s2.decide))
		else $error("result raised without a decided word");

	a_s1_no_clobber: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> !v_s1 || s1_move)
		else $error("new word taken over a stalled line store stage");

	a_s2_fill: assert property (@(posedge clk) disable iff (!arst_n)
		s1_move |=> v_s2)
		else $error("window shift left the compare stage empty");

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for local_maximum_3x3_detector: raster frames of random, tied and
// extreme pixels with flush and ignored drain words, checked against an in-bench predictor.
// Depends on lmd_pkg and the detector RTL.
module tb;
	import lmd_pkg::*;

	localparam int EFF_MAX_W = 1024;
	localparam int EFF_MAX_H = 4096;
	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 8;
	localparam int RANDOM_WORDS = 150;

	typedef logic signed [PIXEL_BITS-1:0] pix_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write;
	cfg_reg_t cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	logic pixel_valid;
	logic pixel_ready;
	in_word_t pixel;
	logic result_valid;
	logic result_ready = 1'b0;
	out_word_t result;

	logic [WIDTH_REG_BITS-1:0] width_reg;
	logic [HEIGHT_REG_BITS-1:0] height_reg;
	pix_t upper_row [EFF_MAX_W];
	pix_t middle_row [EFF_MAX_W];
	pix_t win [9];
	pix_t hood [3][3];
	int in_col;
	int in_row;
	int flush_taken;
	out_word_t pending_decisions [$];
	out_word_t want;

	int errors = 0;
	int words_taken = 0;
	int decisions_checked = 0;
	int maxima_seen = 0;
	int settings_applied = 0;
	int tx_idle_pct = 16;
	int rx_idle_pct = 16;
	int holds_asked = 0;
	int holds_served = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	local_maximum_3x3_detector DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pixel_valid(pixel_valid),
		.pixel_ready(pixel_ready),
		.pixel(pixel),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always #1 clk = ~clk;

	// Decides the center of hood; neighbours outside the frame are skipped.
	function automatic out_word_t judge_pixel(input int dr, input int dc, input int w, input int h);
		out_word_t o;
		int i, j, rr, cc;
		o.is_maximum = 1'b1;
		for (i = 0; i < 3; i++) begin
			for (j = 0; j < 3; j++) begin
				rr = dr - 1 + i;
				cc = dc - 1 + j;
				if (!(i == 1 && j == 1) && rr >= 0 && rr < h && cc >= 0 && cc < w &&
						hood[1][1] < hood[i][j])
					o.is_maximum = 1'b0;
			end
		end
		o.value = hood[1][1];
		o.row = ROW_OUT_BITS'(dr);
		o.column = COL_OUT_BITS'(dc);
		o.frame_end = (dr == h - 1 && dc == w - 1);
		return o;
	endfunction

	function automatic void absorb_word(input in_word_t wd);
		int w, h, i, j;
		bit in_frame;
		pix_t sample;
		w = (width_reg == 0) ? 1 : (width_reg > EFF_MAX_W) ? EFF_MAX_W : int'(width_reg);
		h = (height_reg == 0) ? 1 : (height_reg > EFF_MAX_H) ? EFF_MAX_H : int'(height_reg);
		in_frame = in_row < h;
		if (in_frame && wd.drain)
			return;
		words_taken++;
		sample = in_frame ? wd.pixel_value : '0;
		// A row start completes the last pixel of the row two above.
		if (in_col == 0 && in_row >= 2 && in_row - 2 < h) begin
			for (i = 0; i < 3; i++) begin
				hood[i][0] = win[i*3+1];
				hood[i][1] = win[i*3+2];
				hood[i][2] = '0;
			end
			pending_decisions.push_back(judge_pixel(in_row - 2, w - 1, w, h));
		end
		for (i = 0; i < 3; i++) begin
			win[i*3] = win[i*3+1];
			win[i*3+1] = win[i*3+2];
		end
		win[2] = upper_row[in_col];
		win[5] = middle_row[in_col];
		win[8] = sample;
		upper_row[in_col] = middle_row[in_col];
		middle_row[in_col] = sample;
		if (in_col >= 1 && in_row >= 1 && in_row - 1 < h) begin
			for (i = 0; i < 3; i++)
				for (j = 0; j < 3; j++)
					hood[i][j] = win[i*3+j];
			pending_decisions.push_back(judge_pixel(in_row - 1, in_col - 1, w, h));
		end
		if (in_col + 1 >= w) begin
			in_col = 0;
			in_row++;
		end else begin
			in_col++;
		end
		if (!in_frame) begin
			flush_taken++;
			if (flush_taken >= w + 1) begin
				in_col = 0;
				in_row = 0;
				flush_taken = 0;
			end
		end
	endfunction

	task automatic report_field(input string name, input int e, input int a);
		$display("%0t %s mismatch: expected %0d, actual %0d", $time, name, e, a);
		errors++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (pending_decisions.size() == 0) begin
					$display("%0t unexpected result: expected none, actual %p", $time, result);
					errors++;
				end else begin
					want = pending_decisions.pop_front();
					if (result.is_maximum !== want.is_maximum)
						report_field("is_maximum", want.is_maximum, result.is_maximum);
					if (result.value !== want.value)
						report_field("value", int'(want.value), int'(result.value));
					if (result.row !== want.row)
						report_field("row", want.row, result.row);
					if (result.column !== want.column)
						report_field("column", want.column, result.column);
					if (result.frame_end !== want.frame_end)
						report_field("frame_end", want.frame_end, result.frame_end);
					decisions_checked++;
					if (want.is_maximum)
						maxima_seen++;
				end
			end
			if (cfg_write) begin
				if (cfg_index == REG_FRAME_WIDTH)
					width_reg = cfg_data[WIDTH_REG_BITS-1:0];
				else
					height_reg = cfg_data[HEIGHT_REG_BITS-1:0];
				in_col = 0;
				in_row = 0;
				flush_taken = 0;
			end
			if (pixel_valid && pixel_ready)
				absorb_word(pixel);
		end
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			result_ready <= 1'b0;
			hold_left--;
		end else if (holds_served != holds_asked) begin
			holds_served++;
			hold_left = HOLD_CYCLES - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (pixel_valid && pixel_ready) || (result_valid && result_ready) || cfg_write)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t timeout with %0d results outstanding", $time, pending_decisions.size());
			$display("** local_maximum_3x3_detector: FAILED **");
			$finish;
		end
	end

	task automatic send_word(input pix_t v, input bit d);
		in_word_t wd;
		wd.pixel_value = v;
		wd.drain = d;
		if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			pixel_valid <= 1'b0;
			@(posedge clk);
		end
		pixel <= wd;
		pixel_valid <= 1'b1;
		@(posedge clk);
		while (!pixel_ready)
			@(posedge clk);
	endtask

	// The extra edge lets the checker log the last accepted word first.
	task automatic wait_idle();
		pixel_valid <= 1'b0;
		@(posedge clk);
		while (pending_decisions.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic set_frame(input int w, input int h);
		wait_idle();
		cfg_index <= REG_FRAME_WIDTH;
		cfg_data <= CFG_DATA_BITS'(w);
		cfg_write <= 1'b1;
		@(posedge clk);
		cfg_index <= REG_FRAME_HEIGHT;
		cfg_data <= CFG_DATA_BITS'(h);
		@(posedge clk);
		cfg_write <= 1'b0;
		settings_applied++;
	endtask

	function automatic pix_t rand_pix();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return pix_t'(int'($urandom_range(0, 4)) - 2);
			5: return $urandom_range(0, 1) ? pix_t'(16'h7fff) : pix_t'(16'h8000);
			default: return pix_t'($urandom);
		endcase
	endfunction

	// With noise, stray drains fall inside the frame, some flush words carry drain low,
	// and surplus drains may follow the flush.
	task automatic send_frame(input int w, input int h, input bit noise);
		int n;
		for (n = 0; n < w * h; n++) begin
			if (noise && $urandom_range(0, 19) == 0)
				send_word(rand_pix(), 1'b1);
			send_word(rand_pix(), 1'b0);
		end
		for (n = 0; n <= w; n++)
			send_word(rand_pix(), noise ? ($urandom_range(0, 3) != 0) : 1'b1);
		if (noise && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) send_word(rand_pix(), 1'b1);
	endtask

	task automatic test_small_frames();
		set_frame(3, 3);
		send_word(16'sh7fff, 1'b0);
		send_word(16'sh8000, 1'b0);
		send_word(16'sh0000, 1'b0);
		send_word(16'sh0005, 1'b0);
		send_word(16'sh1234, 1'b1);
		send_word(16'sh0005, 1'b0);
		send_word(16'sh0005, 1'b0);
		send_word(16'sh8000, 1'b0);
		send_word(16'sh7fff, 1'b0);
		send_word(16'shffff, 1'b0);
		send_word(16'sh0007, 1'b0);
		repeat (3) send_word(16'sh5555, 1'b1);
		repeat (2) send_word(16'shaaaa, 1'b1);
		set_frame(1, 1);
		send_word(-16'sd5, 1'b0);
		repeat (2) send_word(16'sh0000, 1'b1);
		set_frame(0, 0);
		send_word(16'sh0001, 1'b0);
		send_word(16'sh0002, 1'b0);
		send_word(16'sh0003, 1'b1);
	endtask

	task automatic test_size_limits();
		// Oversized setting that clamps to the largest frame, abandoned once the
		// first pixels of the top row have been decided.
		set_frame(2047, 8191);
		repeat (EFF_MAX_W + 3) send_word(rand_pix(), 1'b0);
	endtask

	task automatic test_backpressure();
		set_frame(8, 6);
		tx_idle_pct = 0;
		holds_asked++;
		send_frame(8, 6, 1'b0);
		tx_idle_pct = 16;
		set_frame(6, 6);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		send_frame(6, 6, 1'b1);
		tx_idle_pct = 16;
		rx_idle_pct = 16;
	endtask

	task automatic test_random_frames();
		int target, w, h;
		target = words_taken + RANDOM_WORDS;
		while (words_taken < target) begin
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
			h = $urandom_range(1, 10);
			set_frame(w, h);
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(1, w * h)) send_word(rand_pix(), 1'b0);
			else
				send_frame(w, h, 1'b1);
		end
	endtask

	initial begin
		int k;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_FRAME_WIDTH;
		cfg_data = '0;
		pixel_valid = 1'b0;
		pixel = '0;
		width_reg = WIDTH_RESET;
		height_reg = HEIGHT_RESET;
		in_col = 0;
		in_row = 0;
		flush_taken = 0;
		for (k = 0; k < EFF_MAX_W; k++) begin
			upper_row[k] = '0;
			middle_row[k] = '0;
		end
		for (k = 0; k < 9; k++)
			win[k] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_small_frames();
		test_size_limits();
		test_backpressure();
		test_random_frames();
		wait_idle();
		$display("Covered %0d frame settings, %0d accepted words, %0d decisions checked (%0d maxima).",
			settings_applied, words_taken, decisions_checked, maxima_seen);
		if (errors == 0)
			$display("** local_maximum_3x3_detector: PASSED **");
		else
			$display("** local_maximum_3x3_detector: FAILED **");
		$finish;
	end

endmodule

/* sim.f */
src/lmd_pkg.sv
src/lmd_ctrl.sv
src/lmd_line_store.sv
src/lmd_window.sv
src/local_maximum_3x3_detector.sv
tb/sv/tb.sv
